@@ hdl/tcce_pkg.sv @@
// shared types and constants for the text console cursor engine
package tcce_pkg;

  localparam int unsigned SCREEN_WIDTH  = 80;
  localparam int unsigned SCREEN_HEIGHT = 25;
  localparam int unsigned TAB_STOP      = 4;

  localparam int unsigned COL_W  = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned RUN_W  = COL_W + 1;
  localparam int unsigned CELL_W = 11;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned WORD_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h07;

  typedef enum logic {
    KIND_PRINT = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef enum logic {
    OP_FILL   = 1'b0,
    OP_SCROLL = 1'b1
  } op_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cursor_t;

  typedef struct packed {
    op_e               op;
    logic [CELL_W-1:0] start_cell;
    logic [CELL_W-1:0] run_length;
    logic [WORD_W-1:0] cell_word;
    logic [CELL_W-1:0] cursor_pos;
    logic              last;
  } res_t;

  // everything the placement logic decides for one request
  typedef struct packed {
    logic    need_scroll;
    cursor_t cursor_next;
    res_t    scroll_res;
    res_t    main_res;
  } place_t;

endpackage

@@ hdl/tcce_if.sv @@
// request and result channel interfaces of the cursor engine
interface tcce_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink (input valid, kind, char_code, output ready);
endinterface

interface tcce_res_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [10:0] start_cell;
  logic [10:0] run_length;
  logic [15:0] cell_word;
  logic [10:0] cursor_pos;
  logic        last;

  modport source (output valid, op, start_cell, run_length, cell_word, cursor_pos, last,
                  input ready);
  modport sink (input valid, op, start_cell, run_length, cell_word, cursor_pos, last,
                output ready);
endinterface

@@ hdl/tcce_place.sv @@
// placement logic: fill runs and next cursor for one request
module tcce_place import tcce_pkg::*; (
  input  cmd_t              cmd_i,
  input  cursor_t           cursor_i,
  input  logic [CHAR_W-1:0] color_i,
  output place_t            place_o
);

  logic              scroll;
  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_eff;
  logic [RUN_W-1:0]  remain;
  logic [RUN_W-1:0]  tab_run;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  col_sum;
  logic [CHAR_W-1:0] ch_word;
  cursor_t           nxt;
  logic [CELL_W-1:0] start;
  logic [CELL_W-1:0] pos_next;

  always_comb begin
    scroll  = (cursor_i.row >= ROW_W'(SCREEN_HEIGHT));
    col_eff = scroll ? '0 : cursor_i.col;
    row_eff = scroll ? ROW_W'(SCREEN_HEIGHT - 1) : cursor_i.row;

    remain  = RUN_W'(SCREEN_WIDTH) - {1'b0, col_eff};
    tab_run = RUN_W'(TAB_STOP) - RUN_W'(col_eff % COL_W'(TAB_STOP));

    if (cmd_i.char_code == CH_NEWLINE) begin
      run     = remain;
      ch_word = CH_SPACE;
    end else if (cmd_i.char_code == CH_TAB) begin
      run     = (tab_run > remain) ? remain : tab_run;
      ch_word = CH_SPACE;
    end else begin
      run     = RUN_W'(1);
      ch_word = cmd_i.char_code;
    end

    col_sum = {1'b0, col_eff} + run;
    if (col_sum >= RUN_W'(SCREEN_WIDTH)) begin
      nxt.col = '0;
      nxt.row = row_eff + ROW_W'(1);
    end else begin
      nxt.col = col_sum[COL_W-1:0];
      nxt.row = row_eff;
    end

    start = CELL_W'(row_eff) * CELL_W'(SCREEN_WIDTH) + CELL_W'(col_eff);

    // clear screen overrides everything, pending scroll included
    if (cmd_i.kind == KIND_CLEAR) begin
      nxt = '0;
    end
    pos_next = CELL_W'(nxt.row) * CELL_W'(SCREEN_WIDTH) + CELL_W'(nxt.col);

    place_o.need_scroll = scroll && (cmd_i.kind == KIND_PRINT);
    place_o.cursor_next = nxt;

    place_o.scroll_res.op         = OP_SCROLL;
    place_o.scroll_res.start_cell = CELL_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
    place_o.scroll_res.run_length = CELL_W'(SCREEN_WIDTH);
    place_o.scroll_res.cell_word  = {color_i, CH_SPACE};
    place_o.scroll_res.cursor_pos = pos_next;
    place_o.scroll_res.last       = 1'b0;

    place_o.main_res.op         = OP_FILL;
    place_o.main_res.cursor_pos = pos_next;
    place_o.main_res.last       = 1'b1;
    if (cmd_i.kind == KIND_CLEAR) begin
      place_o.main_res.start_cell = '0;
      place_o.main_res.run_length = CELL_W'(SCREEN_WIDTH * SCREEN_HEIGHT);
      place_o.main_res.cell_word  = {color_i, CH_SPACE};
    end else begin
      place_o.main_res.start_cell = start;
      place_o.main_res.run_length = CELL_W'(run);
      place_o.main_res.cell_word  = {color_i, ch_word};
    end
  end

endmodule

@@ hdl/text_console_cursor_engine_unit.sv @@
// top level of the text console cursor engine
//
// Turns a stream of print / clear-screen requests into fill and scroll
// commands for an 80x25 text cell store, tracking the cursor in between.
// A request is latched into an input register; short placement logic then
// computes its fill run and the next cursor and loads the result register.
// Requests are taken one per cycle while the result channel is not stalled; a
// request that meets a pending scroll (cursor below the bottom row) produces
// two results, the scroll first, and holds the input register until both are
// loaded, since both leave through the single result register. The colour
// register may be written whenever no request is in flight.
module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              color_we_i,
  input  logic [CHAR_W-1:0] color_wdata_i,
  tcce_cmd_if.sink          cmd_i,
  tcce_res_if.source        res_o
);

  // input register
  logic              s1_valid_q, s1_valid_d;
  cmd_t              s1_q, s1_d;
  // set once the scroll result of the held request is loaded into the result register
  logic              phase_q, phase_d;
  // cursor and colour state
  cursor_t           cursor_q, cursor_d;
  logic [CHAR_W-1:0] color_q, color_d;
  // result register
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  place_t            place;
  logic              out_load;
  logic              s1_done;
  logic              cmd_take;

  tcce_place u_place (
    .cmd_i    (s1_q),
    .cursor_i (cursor_q),
    .color_i  (color_q),
    .place_o  (place)
  );

  always_comb begin
    // result register frees up when empty or being drained
    out_load = !out_valid_q || res_o.ready;
    // held request retires after its last result is loaded
    s1_done  = s1_valid_q && out_load && (!place.need_scroll || phase_q);
    cmd_take = cmd_i.valid && cmd_i.ready;

    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (cmd_take) begin
      s1_valid_d = 1'b1;
      s1_d.kind      = kind_e'(cmd_i.kind);
      s1_d.char_code = cmd_i.char_code;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end

    phase_d = phase_q;
    if (s1_valid_q && out_load) begin
      phase_d = place.need_scroll && !phase_q;
    end

    cursor_d = s1_done ? place.cursor_next : cursor_q;
    color_d  = color_we_i ? color_wdata_i : color_q;

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
      // scroll goes first, then the request's own fill
      out_d = (place.need_scroll && !phase_q) ? place.scroll_res : place.main_res;
    end
  end

  assign cmd_i.ready = !s1_valid_q || s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      cursor_q    <= '0;
      color_q     <= COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      cursor_q    <= cursor_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.op         = out_q.op;
  assign res_o.start_cell = out_q.start_cell;
  assign res_o.run_length = out_q.run_length;
  assign res_o.cell_word  = out_q.cell_word;
  assign res_o.cursor_pos = out_q.cursor_pos;
  assign res_o.last       = out_q.last;

endmodule
